@@ design/sort_and_merge_two_lists_unit_assert.svh @@
// Assertion macros for the sorter/merger unit.
`ifndef SORT_AND_MERGE_TWO_LISTS_UNIT_ASSERT_SVH
`define SORT_AND_MERGE_TWO_LISTS_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMTL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/smtl_pkg.sv @@
package smtl_pkg;

    // Width of one element value
    localparam int DATA_W = 32;

    // Default capacity of each list
    localparam int DEFAULT_LIST_DEPTH = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_READ,
        ST_INS_CMP,
        ST_MRG_READ,
        ST_MRG_CMP,
        ST_OUT
    } smtl_state_t;

endpackage

@@ design/smtl_list_ram.sv @@
module smtl_list_ram #(
    parameter int DEPTH = smtl_pkg::DEFAULT_LIST_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [ADDR_W-1:0]                  wr_addr,
    input  logic signed [smtl_pkg::DATA_W-1:0] wr_data,
    input  logic                               rd_en,
    input  logic [ADDR_W-1:0]                  rd_addr,
    output logic signed [smtl_pkg::DATA_W-1:0] rd_data
);

    logic signed [smtl_pkg::DATA_W-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/sort_and_merge_two_lists_unit.sv @@
// Two-list sorter and merger. Each input beat carries a signed 32-bit value and
// the list it joins (list_select 0 or 1); the value is placed into that list in
// ascending order by insertion, one compare-and-shift step at a time through a
// single shared signed comparator and a two-port RAM per list. A beat for a
// list that already holds LIST_DEPTH values is dropped, but its end_of_set flag
// still counts. A beat with end_of_set high closes the set: both lists are
// merged into one ascending run of output beats, the second list winning ties,
// with last_of_run high on the final beat; both lists are then empty again.
// Flow: the input stalls while an item is in work. An inserted value alternates
// a RAM read of the neighbor below its hole with a compare that writes either
// that neighbor one slot up or the value itself where it comes to rest; at the
// bottom slot the read step writes the value. A dropped value needs no steps.
// Each merged output beat passes a RAM read, a compare and the output register,
// which holds while the output is stalled. RAM contents need no clearing at reset.
module sort_and_merge_two_lists_unit #(
    parameter int LIST_DEPTH = smtl_pkg::DEFAULT_LIST_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               list_select,
    input  logic signed [smtl_pkg::DATA_W-1:0] value,
    input  logic                               end_of_set,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [smtl_pkg::DATA_W-1:0] merged_value,
    output logic                               last_of_run
);

    import smtl_pkg::*;

    `include "sort_and_merge_two_lists_unit_assert.svh"

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

    smtl_state_t state_reg, state_next;

    logic                     sel_reg, sel_next;
    logic                     fin_reg, fin_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         first_count_reg, first_count_next;
    logic [CNT_W-1:0]         second_count_reg, second_count_next;
    logic [CNT_W-1:0]         idx_a_reg, idx_a_next;
    logic [CNT_W-1:0]         idx_b_reg, idx_b_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic                     out_last_reg, out_last_next;

    // RAM ports
    logic                     first_wr_en, second_wr_en;
    logic                     first_rd_en, second_rd_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]         first_rd_addr, second_rd_addr;
    logic signed [DATA_W-1:0] first_rd_data, second_rd_data;

    // Shared comparator and helpers
    logic signed [DATA_W-1:0] cmp_a, cmp_b;
    logic                     a_lt_b;
    logic                     in_accept;
    logic [CNT_W-1:0]         in_target_cnt;
    logic [CNT_W-1:0]         cur_target_cnt;
    logic [CNT_W-1:0]         pos_dec;
    logic signed [DATA_W-1:0] target_rd_data;
    logic                     shift_step;
    logic                     take_first;
    logic [CNT_W-1:0]         idx_a_inc, idx_b_inc;
    logic                     any_held;

    smtl_list_ram #(
        .DEPTH (LIST_DEPTH)
    ) u_first_ram (
        .clk     (clk),
        .wr_en   (first_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (first_rd_en),
        .rd_addr (first_rd_addr),
        .rd_data (first_rd_data)
    );

    smtl_list_ram #(
        .DEPTH (LIST_DEPTH)
    ) u_second_ram (
        .clk     (clk),
        .wr_en   (second_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (second_rd_en),
        .rd_addr (second_rd_addr),
        .rd_data (second_rd_data)
    );

    // Common decodes
    assign in_accept      = in_valid && !in_stall;
    assign in_target_cnt  = list_select ? second_count_reg : first_count_reg;
    assign cur_target_cnt = sel_reg ? second_count_reg : first_count_reg;
    assign pos_dec        = pos_reg - 1'b1;
    assign target_rd_data = sel_reg ? second_rd_data : first_rd_data;
    assign any_held       = (first_count_reg != '0) || (second_count_reg != '0);

    // Shared signed compare: insertion or merge operands
    always_comb
    begin
        if (state_reg == ST_INS_CMP)
        begin
            cmp_a = key_reg;
            cmp_b = target_rd_data;
        end
        else
        begin
            cmp_a = first_rd_data;
            cmp_b = second_rd_data;
        end
    end

    assign a_lt_b     = cmp_a < cmp_b;
    assign shift_step = a_lt_b;
    assign take_first = (idx_a_reg < first_count_reg)
                        && ((idx_b_reg >= second_count_reg) || a_lt_b);
    assign idx_a_inc  = idx_a_reg + 1'b1;
    assign idx_b_inc  = idx_b_reg + 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_target_cnt != FULL_CNT)
                    begin
                        state_next = ST_INS_READ;
                    end
                    else if (end_of_set && any_held)
                    begin
                        state_next = ST_MRG_READ;
                    end
                end
            end
            ST_INS_READ:
            begin
                if (pos_reg != '0)
                begin
                    state_next = ST_INS_CMP;
                end
                else
                begin
                    state_next = fin_reg ? ST_MRG_READ : ST_IDLE;
                end
            end
            ST_INS_CMP:
            begin
                if (shift_step)
                begin
                    state_next = ST_INS_READ;
                end
                else
                begin
                    state_next = fin_reg ? ST_MRG_READ : ST_IDLE;
                end
            end
            ST_MRG_READ:
            begin
                state_next = ST_MRG_CMP;
            end
            ST_MRG_CMP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = out_last_reg ? ST_IDLE : ST_MRG_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        sel_next          = sel_reg;
        fin_next          = fin_reg;
        key_next          = key_reg;
        pos_next          = pos_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        idx_a_next        = idx_a_reg;
        idx_b_next        = idx_b_reg;
        out_value_next    = out_value_reg;
        out_last_next     = out_last_reg;
        first_wr_en       = 1'b0;
        second_wr_en      = 1'b0;
        first_rd_en       = 1'b0;
        second_rd_en      = 1'b0;
        wr_addr           = pos_reg[IDX_W-1:0];
        wr_data           = key_reg;
        first_rd_addr     = pos_dec[IDX_W-1:0];
        second_rd_addr    = pos_dec[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_a_next = '0;
                idx_b_next = '0;
                if (in_accept)
                begin
                    sel_next = list_select;
                    fin_next = end_of_set;
                    key_next = value;
                    pos_next = in_target_cnt;
                end
            end
            ST_INS_READ:
            begin
                if (pos_reg != '0)
                begin
                    // fetch the neighbor below the hole
                    first_rd_en  = !sel_reg;
                    second_rd_en = sel_reg;
                end
                else
                begin
                    // place the key at the bottom
                    first_wr_en  = !sel_reg;
                    second_wr_en = sel_reg;
                    if (sel_reg)
                    begin
                        second_count_next = second_count_reg + 1'b1;
                    end
                    else
                    begin
                        first_count_next = first_count_reg + 1'b1;
                    end
                end
            end
            ST_INS_CMP:
            begin
                first_wr_en  = !sel_reg;
                second_wr_en = sel_reg;
                if (shift_step)
                begin
                    // move the larger neighbor up one slot
                    wr_data  = target_rd_data;
                    pos_next = pos_dec;
                end
                else if (sel_reg)
                begin
                    second_count_next = cur_target_cnt + 1'b1;
                end
                else
                begin
                    first_count_next = cur_target_cnt + 1'b1;
                end
            end
            ST_MRG_READ:
            begin
                first_rd_en    = 1'b1;
                second_rd_en   = 1'b1;
                first_rd_addr  = idx_a_reg[IDX_W-1:0];
                second_rd_addr = idx_b_reg[IDX_W-1:0];
            end
            ST_MRG_CMP:
            begin
                if (take_first)
                begin
                    out_value_next = first_rd_data;
                    idx_a_next     = idx_a_inc;
                    out_last_next  = (idx_a_inc == first_count_reg)
                                     && (idx_b_reg == second_count_reg);
                end
                else
                begin
                    out_value_next = second_rd_data;
                    idx_b_next     = idx_b_inc;
                    out_last_next  = (idx_a_reg == first_count_reg)
                                     && (idx_b_inc == second_count_reg);
                end
            end
            ST_OUT:
            begin
                if (!out_stall && out_last_reg)
                begin
                    // run done: empty both lists
                    first_count_next  = '0;
                    second_count_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            pos_reg          <= '0;
            idx_a_reg        <= '0;
            idx_b_reg        <= '0;
            out_last_reg     <= 1'b0;
            sel_reg          <= 1'b0;
            fin_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            pos_reg          <= pos_next;
            idx_a_reg        <= idx_a_next;
            idx_b_reg        <= idx_b_next;
            out_last_reg     <= out_last_next;
            sel_reg          <= sel_next;
            fin_reg          <= fin_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        out_value_reg <= out_value_next;
    end

    // Handshake outputs
    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = (state_reg == ST_OUT);
    assign merged_value = out_value_reg;
    assign last_of_run  = out_last_reg;

    `SMTL_ASSERT_NOW(a_out_has_data, clk, rst_n, out_valid, any_held, "output beat with both lists empty")
    `SMTL_ASSERT_NOW(a_merge_in_range, clk, rst_n, state_reg == ST_MRG_CMP, (idx_a_reg < first_count_reg) || (idx_b_reg < second_count_reg), "merge step past both lists")
    `SMTL_ASSERT_NEXT(a_run_end_clears, clk, rst_n, out_valid && !out_stall && last_of_run, (state_reg == ST_IDLE) && !any_held, "lists not emptied after last beat")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH = smtl_pkg::DEFAULT_LIST_DEPTH;
    localparam int W     = smtl_pkg::DATA_W;

    typedef logic signed [W-1:0] word_t;

    localparam word_t MIN_WORD = {1'b1, {(W-1){1'b0}}};
    localparam word_t MAX_WORD = {1'b0, {(W-1){1'b1}}};

    typedef struct {
        word_t merged_value;
        logic  last_of_run;
    } beat_t;

    typedef struct {
        bit    sel;
        word_t val;
        bit    eos;
        bit    typed;
        word_t want;
    } step_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid    = 1'b0;
    logic  in_stall;
    logic  list_select = 1'b0;
    word_t value       = '0;
    logic  end_of_set  = 1'b0;
    logic  out_valid;
    logic  out_stall   = 1'b0;
    word_t merged_value;
    logic  last_of_run;

    // Sorted copies of both lists and the merged beats still owed by the block
    word_t first_list[$];
    word_t second_list[$];
    beat_t run_beats[$];
    beat_t merge_due[$];

    int error_count   = 0;
    int beats_checked = 0;
    int items_sent    = 0;
    int sets_closed   = 0;
    int dropped_items = 0;

    sort_and_merge_two_lists_unit #(
        .LIST_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .list_select(list_select),
        .value(value),
        .end_of_set(end_of_set),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .merged_value(merged_value),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Guard against a hung block
    initial
    begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (error_count < 30)
            $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Place a value into a list in ascending order, drop it when the list is full
    function automatic void insert_sorted(ref word_t list[$], input word_t v);
        int pos;
        if (list.size() >= DEPTH)
        begin
            dropped_items++;
            return;
        end
        pos = list.size();
        while (pos > 0 && list[pos-1] > v)
            pos--;
        list.insert(pos, v);
    endfunction

    // Load one beat; on end of set merge both lists into run_beats and empty them
    function automatic void predict_item(input bit sel, input word_t v, input bit eos);
        int    i;
        int    j;
        beat_t b;
        run_beats.delete();
        if (sel == 1'b0)
            insert_sorted(first_list, v);
        else
            insert_sorted(second_list, v);
        if (!eos)
            return;
        i = 0;
        j = 0;
        while (i < first_list.size() || j < second_list.size())
        begin
            // take from the second list on ties
            if (i < first_list.size() &&
                (j >= second_list.size() || first_list[i] < second_list[j]))
            begin
                b.merged_value = first_list[i];
                i++;
            end
            else
            begin
                b.merged_value = second_list[j];
                j++;
            end
            b.last_of_run = 1'b0;
            run_beats.push_back(b);
        end
        // an empty set closes with no beats at all
        if (run_beats.size() != 0)
            run_beats[run_beats.size()-1].last_of_run = 1'b1;
        first_list.delete();
        second_list.delete();
    endfunction

    function automatic word_t pick_value();
        case ($urandom_range(0, 11))
            0:       return MIN_WORD;
            1:       return MAX_WORD;
            2, 3:    return word_t'($urandom_range(0, 6)) - 3;
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Present one beat, hold it until accepted, then record what it owes
    task automatic offer(input bit sel, input word_t v, input bit eos,
                         input bit typed, input word_t want);
        int k;
        @(negedge clk);
        in_valid    <= 1'b1;
        list_select <= sel;
        value       <= v;
        end_of_set  <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(sel, v, eos);
        if (typed)
            merge_due.push_back('{merged_value: want, last_of_run: 1'b1});
        else
            for (k = 0; k < run_beats.size(); k++)
                merge_due.push_back(run_beats[k]);
        items_sent++;
        if (eos)
            sets_closed++;
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Drop valid and hold until every owed beat has come back
    task automatic drain_pause();
        @(negedge clk);
        in_valid <= 1'b0;
        while (merge_due.size() != 0)
            @(posedge clk);
    endtask

    // Stall the output: random short and long runs, calm stretches, one long hold
    initial
    begin : drive_out_stall
        int stall_left;
        int calm_left;
        int hold_left;
        int roll;
        bit held_off;
        bit stall_now;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        held_off   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && beats_checked >= 40)
            begin
                held_off  = 1'b1;
                hold_left = 400;
            end
            stall_now = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_now = 1'b1;
            end
            else if (calm_left > 0)
                calm_left--;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    calm_left = $urandom_range(30, 120);
                else if (roll < 8)
                    stall_left = $urandom_range(10, 50);
                else if (roll < 30)
                begin
                    stall_left = $urandom_range(0, 2);
                    stall_now  = 1'b1;
                end
            end
            out_stall <= stall_now;
        end
    end

    // Compare each accepted output beat with the oldest owed beat
    always @(posedge clk)
    begin : check_beats
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (merge_due.size() == 0)
                report_mismatch($sformatf("unexpected beat value %0d last %0b",
                                          merged_value, last_of_run));
            else
            begin
                want = merge_due.pop_front();
                if (merged_value !== want.merged_value)
                    report_mismatch($sformatf("merged_value %0d, want %0d",
                                              merged_value, want.merged_value));
                if (last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, want %0b on value %0d",
                                              last_of_run, want.last_of_run,
                                              want.merged_value));
            end
            beats_checked++;
        end
    end

    initial
    begin : stimulus
        step_t steps[] = '{
            // one-value sets: extremes, zero, minus one and alternating bit patterns
            '{1'b0, MIN_WORD,              1'b1, 1'b1, MIN_WORD},
            '{1'b1, MAX_WORD,              1'b1, 1'b1, MAX_WORD},
            '{1'b0, 32'sd0,                1'b1, 1'b1, 32'sd0},
            '{1'b1, -32'sd1,               1'b1, 1'b1, -32'sd1},
            '{1'b0, word_t'(32'h5555_5555), 1'b1, 1'b1, word_t'(32'h5555_5555)},
            '{1'b1, word_t'(32'hAAAA_AAAA), 1'b1, 1'b1, word_t'(32'hAAAA_AAAA)},
            // equal values in both lists, second list first
            '{1'b0, 32'sd5,                1'b0, 1'b0, '0},
            '{1'b1, 32'sd5,                1'b0, 1'b0, '0},
            '{1'b0, -32'sd3,               1'b0, 1'b0, '0},
            '{1'b1, 32'sd5,                1'b0, 1'b0, '0},
            '{1'b0, MAX_WORD,              1'b0, 1'b0, '0},
            '{1'b1, MIN_WORD,              1'b1, 1'b0, '0},
            // first list only, loaded descending
            '{1'b0, 32'sd3,                1'b0, 1'b0, '0},
            '{1'b0, 32'sd2,                1'b0, 1'b0, '0},
            '{1'b0, 32'sd1,                1'b0, 1'b0, '0},
            '{1'b0, MIN_WORD,              1'b1, 1'b0, '0},
            // second list only
            '{1'b1, 32'sd100,              1'b0, 1'b0, '0},
            '{1'b1, -32'sd100,             1'b0, 1'b0, '0},
            '{1'b1, MAX_WORD,              1'b1, 1'b0, '0},
            // first list runs out early, rest of the second list follows
            '{1'b0, -32'sd50,              1'b0, 1'b0, '0},
            '{1'b1, 32'sd10,               1'b0, 1'b0, '0},
            '{1'b1, 32'sd20,               1'b1, 1'b0, '0}
        };
        int k;
        int n;
        int bias;
        int set_idx;
        bit calm;
        bit sel;

        @(posedge rst_n);

        // Walk the directed table
        for (k = 0; k < steps.size(); k++)
        begin
            offer(steps[k].sel, steps[k].val, steps[k].eos, steps[k].typed, steps[k].want);
            idle_gap(gap_len());
        end

        // Overfill both lists; the closing beat is itself dropped
        for (k = 0; k < DEPTH + 2; k++)
            offer(1'b0, pick_value(), 1'b0, 1'b0, '0);
        for (k = 0; k < DEPTH + 1; k++)
            offer(1'b1, pick_value(), k == DEPTH, 1'b0, '0);

        // Random sets, mostly small, a few past capacity
        set_idx = 0;
        while (items_sent < 300)
        begin
            if (set_idx == 8)
                drain_pause();
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                               : $urandom_range(1, 10);
            // keep the last set inside the item budget
            if (n > 300 - items_sent)
                n = 300 - items_sent;
            bias = $urandom_range(0, 3);
            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < n; k++)
            begin
                if (bias == 0)
                    sel = 1'b0;
                else if (bias == 1)
                    sel = 1'b1;
                else
                    sel = $urandom_range(0, 1);
                offer(sel, pick_value(), k == n - 1, 1'b0, '0);
                if (!calm)
                    idle_gap(gap_len());
            end
            set_idx++;
        end

        // Drain and let any late beat show up
        @(negedge clk);
        in_valid <= 1'b0;
        while (merge_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("run: %0d input beats in %0d sets, %0d dropped on a full list",
                 items_sent, sets_closed, dropped_items);
        $display("run: %0d merged beats checked, %0d mismatches",
                 beats_checked, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/smtl_pkg.sv
design/smtl_list_ram.sv
design/sort_and_merge_two_lists_unit.sv
dv/tb.sv
